@@ hw/rtl/alpd_pkg.sv @@
// ----------------------------------------------------------------------------
// alpd_pkg
// Shared types and constants for the averaged level to PWM duty block.
// ----------------------------------------------------------------------------
package alpd_pkg;

    localparam int SAMPLE_W    = 10;
    localparam int DUTY_W      = 8;
    localparam int PCT_W       = 7;

    localparam int LEVEL_TOP   = 1023;
    localparam int DUTY_TOP    = 255;
    localparam int PERCENT_TOP = 100;

    // Stream data widths, rounded up to whole bytes.
    localparam int IN_DATA_W   = ((SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((DUTY_W + PCT_W + 7) / 8) * 8;

    // The widest dividend is avg * 255 with avg below 1024, and the widest
    // divisor is 1023, so these cover every division the block performs.
    localparam int DIV_NUM_W   = 18;
    localparam int DIV_DEN_W   = 10;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_DUTY_GO,
        ST_DUTY_WAIT,
        ST_PCT_GO,
        ST_PCT_WAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

@@ hw/rtl/alpd_ram.sv @@
// ----------------------------------------------------------------------------
// alpd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module alpd_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/alpd_serdiv.sv @@
// ----------------------------------------------------------------------------
// alpd_serdiv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module alpd_serdiv import alpd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_NUM_W);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_num;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   w_trial;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_ge;
    logic [DIV_DEN_W-1:0] n_rem;
    logic [DIV_NUM_W-1:0] n_num;

    // The dividend shifts out of the top of r_num while quotient bits shift
    // in at the bottom, so r_num holds the quotient once all bits are done.
    always_comb begin
        w_trial = {r_rem, r_num[DIV_NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[DIV_DEN_W-1:0] : w_trial[DIV_DEN_W-1:0];
        n_num   = {r_num[DIV_NUM_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= '0;
            r_num <= i_req.num;
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= n_num;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_num;

endmodule

@@ hw/rtl/averaged_level_to_pwm_duty.sv @@
// ----------------------------------------------------------------------------
// averaged_level_to_pwm_duty
// Moving average of converter samples in a ring, scaled to an 8-bit PWM duty
// and a brightness percentage, with a refresh flag for display ticks.
//
//   Channel  Dir  Signals                     Contents
//   s        in   i_s_tvalid/o_s_tready       tdata: sample; tuser: kind
//   m        out  o_m_tvalid/i_m_tready       tdata: duty, percent;
//                                             tuser: duty_update, display_update
//
// A sample word goes from its accepting cycle through the sum update, three
// passes of the bit-serial divider (a start and a wait state each) for the
// average, the duty and the percentage, to the output load. A display tick
// goes from its accepting cycle straight to the output load. One word is
// worked on at a time. Reset is synchronous and clears the sum, the ring
// valid flags and all status, not the ring memory. A loaded result waiting
// on i_m_tready blocks the next word only once that word's result is ready.
// ----------------------------------------------------------------------------
module averaged_level_to_pwm_duty import alpd_pkg::*; #(
    parameter int WINDOW      = 8,
    parameter int SAMPLE_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [9:0] sample, rest zero
    input  logic [0:0]            i_s_tuser,   // [0] kind
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [7:0] duty, [14:8] percent, rest zero
    output logic [1:0]            o_m_tuser    // [0] duty_update, [1] display_update
);

    localparam int LEVEL_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
    localparam int LEVEL_MAX  = (1 << LEVEL_BITS) - 1;
    localparam int SUM_MAX    = WINDOW * LEVEL_MAX;
    localparam int SUM_W      = $clog2(SUM_MAX + 1);
    localparam int SLOT_W     = $clog2(WINDOW);
    localparam logic [SAMPLE_W-1:0] LEVEL_MASK = SAMPLE_W'(LEVEL_MAX);

    t_state r_state;
    t_state n_state;

    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_level;
    logic [SUM_W-1:0]    r_sum;
    logic [SUM_W-1:0]    n_sum;
    logic [SLOT_W-1:0]   r_slot;
    logic [SLOT_W-1:0]   n_slot;
    logic [WINDOW-1:0]   r_ring_valid;
    logic [DUTY_W-1:0]   r_last_duty;
    logic [PCT_W-1:0]    r_cur_pct;
    logic [PCT_W-1:0]    r_shown_pct;
    logic                r_shown_valid;
    logic                r_res_dupd;
    logic                r_res_disp;
    logic [DUTY_W-1:0]   r_o_duty;
    logic [PCT_W-1:0]    r_o_pct;
    logic                r_o_dupd;
    logic                r_o_disp;

    logic                w_s_acc;
    logic                w_is_tick;
    logic                w_out_free;
    logic                w_ram_we;
    logic                w_duty_cap;
    logic                w_pct_cap;
    logic                w_out_load;
    logic                w_tick_disp;
    logic [SAMPLE_W-1:0] w_ring_rdata;
    logic [SAMPLE_W-1:0] w_old;
    logic [DUTY_W-1:0]   w_duty;
    logic [PCT_W-1:0]    w_pct;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    assign w_s_acc     = i_s_tvalid && o_s_tready;
    assign w_is_tick   = (i_s_tuser[0] == KIND_TICK);
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_tick_disp = !r_shown_valid || (r_cur_pct != r_shown_pct);

    // Entries not written since reset read as zero.
    assign w_old  = r_ring_valid[r_slot] ? w_ring_rdata : '0;
    assign n_sum  = r_sum - SUM_W'(w_old) + SUM_W'(r_level);
    assign n_slot = (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);

    assign w_duty = (w_div_rsp.quot > DIV_NUM_W'(DUTY_TOP)) ?
                    DUTY_W'(DUTY_TOP) : w_div_rsp.quot[DUTY_W-1:0];
    assign w_pct  = (w_div_rsp.quot > DIV_NUM_W'(PERCENT_TOP)) ?
                    PCT_W'(PERCENT_TOP) : w_div_rsp.quot[PCT_W-1:0];

    // The read address follows r_slot, so the old entry is ready in ST_SUM.
    alpd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_level),
        .i_raddr (r_slot),
        .o_rdata (w_ring_rdata)
    );

    alpd_serdiv u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_s_acc) begin
                    n_state = w_is_tick ? ST_OUT : ST_SUM;
                end
            end
            ST_SUM:       n_state = ST_AVG_GO;
            ST_AVG_GO:    n_state = ST_AVG_WAIT;
            ST_AVG_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = ST_DUTY_GO;
                end
            end
            ST_DUTY_GO:   n_state = ST_DUTY_WAIT;
            ST_DUTY_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = ST_PCT_GO;
                end
            end
            ST_PCT_GO:    n_state = ST_PCT_WAIT;
            ST_PCT_WAIT: begin
                if (w_div_rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready      = 1'b0;
        w_ram_we        = 1'b0;
        w_duty_cap      = 1'b0;
        w_pct_cap       = 1'b0;
        w_out_load      = 1'b0;
        w_div_req.start = 1'b0;
        w_div_req.num   = '0;
        w_div_req.den   = DIV_DEN_W'(WINDOW);
        case (r_state)
            ST_IDLE:      o_s_tready = 1'b1;
            ST_SUM:       w_ram_we = 1'b1;
            ST_AVG_GO: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = DIV_NUM_W'(r_sum);
                w_div_req.den   = DIV_DEN_W'(WINDOW);
            end
            ST_AVG_WAIT:  ;
            ST_DUTY_GO: begin
                // The quotient of the average pass is still in the divider.
                w_div_req.start = 1'b1;
                w_div_req.num   = DIV_NUM_W'(w_div_rsp.quot[SAMPLE_W-1:0])
                                  * DIV_NUM_W'(DUTY_TOP);
                w_div_req.den   = DIV_DEN_W'(LEVEL_TOP);
            end
            ST_DUTY_WAIT: w_duty_cap = w_div_rsp.done;
            ST_PCT_GO: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = DIV_NUM_W'(r_last_duty) * DIV_NUM_W'(PERCENT_TOP);
                w_div_req.den   = DIV_DEN_W'(DUTY_TOP);
            end
            ST_PCT_WAIT:  w_pct_cap = w_div_rsp.done;
            ST_OUT:       w_out_load = w_out_free;
            default:      ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
            r_sum         <= '0;
            r_slot        <= '0;
            r_ring_valid  <= '0;
            r_last_duty   <= '0;
            r_cur_pct     <= '0;
            r_shown_pct   <= '0;
            r_shown_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_ram_we) begin
                r_sum                <= n_sum;
                r_slot               <= n_slot;
                r_ring_valid[r_slot] <= 1'b1;
            end
            if (w_duty_cap) begin
                r_last_duty <= w_duty;
            end
            if (w_pct_cap) begin
                r_cur_pct <= w_pct;
            end
            if (w_s_acc && w_is_tick) begin
                r_shown_pct   <= r_cur_pct;
                r_shown_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_level    <= i_s_tdata[SAMPLE_W-1:0] & LEVEL_MASK;
            r_res_dupd <= !w_is_tick;
            r_res_disp <= w_is_tick && w_tick_disp;
        end
        if (w_out_load) begin
            r_o_duty <= r_last_duty;
            r_o_pct  <= r_cur_pct;
            r_o_dupd <= r_res_dupd;
            r_o_disp <= r_res_disp;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_o_pct, r_o_duty});
    assign o_m_tuser  = {r_o_disp, r_o_dupd};

    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_rsp.busy)
        else $error("divider started while busy");

    a_div_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == ST_AVG_WAIT || r_state == ST_DUTY_WAIT
                            || r_state == ST_PCT_WAIT))
        else $error("divider finished outside a wait state");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= SUM_W'(SUM_MAX))
        else $error("window sum out of range");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_pct <= PCT_W'(PERCENT_TOP))
        else $error("percentage above full scale");

    a_tick_marks_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && w_is_tick) |=> (r_shown_valid && !r_res_dupd
                                    && r_state == ST_OUT))
        else $error("display tick not recorded");

endmodule
